// ----- rtl/cfw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cfw_pkg;

   // fixed point format
   localparam int FRAC_BITS = 16;
   localparam int FRAC_W    = FRAC_BITS + 1;
   localparam logic [FRAC_W-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

   // field widths
   localparam int VEC_W = 24;
   localparam int CO_W  = 20;

   // vectors shrunk for the angle term: magnitudes below 2^(SHR_W-1)
   localparam int SHR_W   = 16;
   localparam int SQ_W    = 2 * SHR_W;
   localparam int MAG_W   = SQ_W - 1;
   localparam int PROD2_W = 2 * MAG_W;

   // front to back queue
   localparam int FIFO_DEPTH = 4;

   // one classified face, handed from the front to the back
   typedef struct packed {
      logic                 kill;
      logic                 den_zero;
      logic [FRAC_BITS-1:0] num;
      logic [FRAC_W-1:0]    den;
      logic [CO_W-1:0]      co;
      logic [PROD2_W-1:0]   n2;
      logic [PROD2_W-1:0]   d2;
   } face_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

`default_nettype wire

// ----- rtl/cfw_div_pipe.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cfw_div_pipe #(
   parameter int REM_W = 17,
   parameter int STEPS = 16,
   parameter int TAG_W = 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_valid,
   input  wire logic [REM_W-1:0] in_rem,
   input  wire logic [REM_W-1:0] in_den,
   input  wire logic [TAG_W-1:0] in_tag,
   output logic                  out_valid,
   output logic [STEPS-1:0]      out_quo,
   output logic [TAG_W-1:0]      out_tag
);

   logic [STEPS-1:0] v_ff;
   logic [REM_W-1:0] rem_ff [STEPS];
   logic [REM_W-1:0] den_ff [STEPS];
   logic [STEPS-1:0] quo_ff [STEPS];
   logic [TAG_W-1:0] tag_ff [STEPS];

   // one quotient bit per stage, remainder kept below the divisor
   for (genvar s = 0; s < STEPS; s++) begin : g_step
      logic             src_v;
      logic [REM_W-1:0] src_rem;
      logic [REM_W-1:0] src_den;
      logic [STEPS-1:0] src_quo;
      logic [TAG_W-1:0] src_tag;
      logic [REM_W:0]   shifted;
      logic [REM_W:0]   diff;
      logic             take;
      logic [REM_W-1:0] rem_in;
      logic [STEPS-1:0] quo_in;

      if (s == 0) begin : g_first
         assign src_v   = in_valid;
         assign src_rem = in_rem;
         assign src_den = in_den;
         assign src_quo = '0;
         assign src_tag = in_tag;
      end else begin : g_next
         assign src_v   = v_ff[s-1];
         assign src_rem = rem_ff[s-1];
         assign src_den = den_ff[s-1];
         assign src_quo = quo_ff[s-1];
         assign src_tag = tag_ff[s-1];
      end

      assign shifted = {src_rem, 1'b0};
      assign take    = shifted >= {1'b0, src_den};
      assign diff    = shifted - {1'b0, src_den};
      assign rem_in  = take ? diff[REM_W-1:0] : shifted[REM_W-1:0];
      assign quo_in  = {src_quo[STEPS-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in;
            den_ff[s] <= src_den;
            quo_ff[s] <= quo_in;
            tag_ff[s] <= src_tag;
         end
      end
   end

   assign out_valid = v_ff[STEPS-1];
   assign out_quo   = quo_ff[STEPS-1];
   assign out_tag   = tag_ff[STEPS-1];

endmodule

`default_nettype wire

// ----- rtl/cfw_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cfw_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [cfw_pkg::FRAC_W-1:0]          req_gamma_donor,
   input  wire logic [cfw_pkg::FRAC_W-1:0]          req_gamma_acceptor,
   input  wire logic signed [cfw_pkg::VEC_W-1:0]    req_dist_x,
   input  wire logic signed [cfw_pkg::VEC_W-1:0]    req_dist_y,
   input  wire logic signed [cfw_pkg::VEC_W-1:0]    req_grad_x,
   input  wire logic signed [cfw_pkg::VEC_W-1:0]    req_grad_y,
   input  wire logic [cfw_pkg::CO_W-1:0]            req_courant_donor,
   input  wire cfw_pkg::fifo_status_type            queue_status,
   output logic                                     push,
   output cfw_pkg::face_item_type                   push_item
);

   import cfw_pkg::*;

   localparam int PROD_W = 2 * VEC_W;
   localparam int DOT_W  = PROD_W + 1;
   localparam int SH_W   = $clog2(VEC_W - SHR_W + 2);
   localparam int DIF_W  = FRAC_W + 2;

   function automatic logic [VEC_W-1:0] mag_of(input logic signed [VEC_W-1:0] v);
      logic [VEC_W-1:0] m;
      m = v[VEC_W-1] ? -v : v;
      return m;
   endfunction

   // right shift that brings the larger magnitude below 2^(SHR_W-1)
   function automatic logic [SH_W-1:0] shrink_sh(input logic [VEC_W-1:0] m);
      logic [SH_W-1:0] sh;
      sh = '0;
      for (int i = SHR_W - 1; i < VEC_W; i++) begin
         if (m[i]) sh = SH_W'(i - (SHR_W - 2));
      end
      return sh;
   endfunction

   function automatic logic signed [SHR_W-1:0] shrink_apply(
      input logic signed [VEC_W-1:0] v,
      input logic [SH_W-1:0]         sh
   );
      logic [VEC_W-1:0] m;
      logic [SHR_W-1:0] s;
      m = mag_of(v) >> sh;
      s = {1'b0, m[SHR_W-2:0]};
      return v[VEC_W-1] ? -s : s;
   endfunction

   logic adv;
   logic f1_valid_ff, f2_valid_ff, f3_valid_ff, f4_valid_ff;

   // whole front moves unless its last stage cannot enter the queue
   assign adv       = !f4_valid_ff || !queue_status.full;
   assign req_stall = !adv;
   assign push      = f4_valid_ff && !queue_status.full;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
         f4_valid_ff <= 1'b0;
      end else if (adv) begin
         f1_valid_ff <= req_valid;
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
         f4_valid_ff <= f3_valid_ff;
      end
   end

   // stage 1: clamp, zero vectors, upwind products, shrunk vectors
   logic [FRAC_W-1:0]              gd1_in, ga1_in, gd1_ff, ga1_ff;
   logic [CO_W-1:0]                co1_ff;
   logic                           zero1_in, zero1_ff;
   logic signed [PROD_W-1:0]       prx1_in, pry1_in, prx1_ff, pry1_ff;
   logic [SH_W-1:0]                shr_in, shg_in;
   logic [VEC_W-1:0]               mrx, mry, mgx, mgy;
   logic signed [SHR_W-1:0]        srx1_ff, sry1_ff, sgx1_ff, sgy1_ff;

   always_comb begin
      gd1_in   = (req_gamma_donor > ONE_Q) ? ONE_Q : req_gamma_donor;
      ga1_in   = (req_gamma_acceptor > ONE_Q) ? ONE_Q : req_gamma_acceptor;
      zero1_in = (req_dist_x == '0 && req_dist_y == '0) ||
                 (req_grad_x == '0 && req_grad_y == '0);
      prx1_in  = req_dist_x * req_grad_x;
      pry1_in  = req_dist_y * req_grad_y;
      mrx      = mag_of(req_dist_x);
      mry      = mag_of(req_dist_y);
      mgx      = mag_of(req_grad_x);
      mgy      = mag_of(req_grad_y);
      shr_in   = shrink_sh((mrx > mry) ? mrx : mry);
      shg_in   = shrink_sh((mgx > mgy) ? mgx : mgy);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         gd1_ff   <= gd1_in;
         ga1_ff   <= ga1_in;
         co1_ff   <= req_courant_donor;
         zero1_ff <= zero1_in;
         prx1_ff  <= prx1_in;
         pry1_ff  <= pry1_in;
         srx1_ff  <= shrink_apply(req_dist_x, shr_in);
         sry1_ff  <= shrink_apply(req_dist_y, shr_in);
         sgx1_ff  <= shrink_apply(req_grad_x, shg_in);
         sgy1_ff  <= shrink_apply(req_grad_y, shg_in);
      end
   end

   // stage 2: upwind value and small products of the shrunk vectors
   logic signed [DOT_W-1:0]  dot_in;
   logic signed [DOT_W:0]    gu_wide;
   logic [FRAC_W-1:0]        gu2_in;
   logic [FRAC_W-1:0]        gd2_ff, ga2_ff, gu2_ff;
   logic [CO_W-1:0]          co2_ff;
   logic                     zero2_ff;
   logic signed [SQ_W-1:0]   prgx2_ff, prgy2_ff, sqrx2_ff, sqry2_ff, sqgx2_ff, sqgy2_ff;

   always_comb begin
      dot_in  = DOT_W'(prx1_ff) + DOT_W'(pry1_ff);
      gu_wide = $signed({{(DOT_W + 1 - FRAC_W){1'b0}}, ga1_ff}) -
                ($signed({dot_in[DOT_W-1], dot_in}) >>> (FRAC_BITS - 1));
      if (gu_wide[DOT_W]) begin
         gu2_in = '0;
      end else if (gu_wide[DOT_W-1:0] > DOT_W'(ONE_Q)) begin
         gu2_in = ONE_Q;
      end else begin
         gu2_in = gu_wide[FRAC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         gd2_ff   <= gd1_ff;
         ga2_ff   <= ga1_ff;
         gu2_ff   <= gu2_in;
         co2_ff   <= co1_ff;
         zero2_ff <= zero1_ff;
         prgx2_ff <= srx1_ff * sgx1_ff;
         prgy2_ff <= sry1_ff * sgy1_ff;
         sqrx2_ff <= srx1_ff * srx1_ff;
         sqry2_ff <= sry1_ff * sry1_ff;
         sqgx2_ff <= sgx1_ff * sgx1_ff;
         sqgy2_ff <= sgy1_ff * sgy1_ff;
      end
   end

   // stage 3: classify the normalized donor value, angle terms
   logic signed [DIF_W-1:0] num_w, den_w;
   logic signed [SQ_W-1:0]  d_w;
   logic [SQ_W-1:0]         ad_w;
   logic                    kill3_in;
   logic                    kill3_ff, dz3_ff;
   logic [FRAC_BITS-1:0]    num3_ff;
   logic [FRAC_W-1:0]       den3_ff;
   logic [CO_W-1:0]         co3_ff;
   logic [MAG_W-1:0]        ad3_ff, sr3_ff, sg3_ff;

   always_comb begin
      num_w = $signed({2'b00, gd2_ff}) - $signed({2'b00, gu2_ff});
      den_w = $signed({2'b00, ga2_ff}) - $signed({2'b00, gu2_ff});
      if (den_w < 0) begin
         num_w = -num_w;
         den_w = -den_w;
      end
      kill3_in = zero2_ff || (den_w != '0 && (num_w < 0 || num_w >= den_w));
      d_w      = prgx2_ff + prgy2_ff;
      ad_w     = d_w[SQ_W-1] ? -d_w : d_w;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         kill3_ff <= kill3_in;
         dz3_ff   <= (den_w == '0);
         num3_ff  <= num_w[FRAC_BITS-1:0];
         den3_ff  <= den_w[FRAC_W-1:0];
         co3_ff   <= co2_ff;
         ad3_ff   <= ad_w[MAG_W-1:0];
         sr3_ff   <= sqrx2_ff[MAG_W-1:0] + sqry2_ff[MAG_W-1:0];
         sg3_ff   <= sqgx2_ff[MAG_W-1:0] + sqgy2_ff[MAG_W-1:0];
      end
   end

   // stage 4: squared dot product against product of squared lengths
   face_item_type f4_item_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         f4_item_ff.kill     <= kill3_ff;
         f4_item_ff.den_zero <= dz3_ff;
         f4_item_ff.num      <= num3_ff;
         f4_item_ff.den      <= den3_ff;
         f4_item_ff.co       <= co3_ff;
         f4_item_ff.n2       <= ad3_ff * ad3_ff;
         f4_item_ff.d2       <= sr3_ff * sg3_ff;
      end
   end

   assign push_item = f4_item_ff;

endmodule

`default_nettype wire

// ----- rtl/cfw_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cfw_queue #(
   parameter int DEPTH = cfw_pkg::FIFO_DEPTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire cfw_pkg::face_item_type push_item,
   input  wire logic                   pop,
   output cfw_pkg::face_item_type      head_item,
   output cfw_pkg::fifo_status_type    status
);

   import cfw_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   face_item_type    mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff, wr_ptr_in, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item    = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

`default_nettype wire

// ----- rtl/cfw_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cfw_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire cfw_pkg::face_item_type     head_item,
   input  wire cfw_pkg::fifo_status_type   queue_status,
   output logic                            pop,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [cfw_pkg::FRAC_W-1:0]      rsp_face_weight
);

   import cfw_pkg::*;

   localparam int CD_W  = CO_W + FRAC_BITS;
   localparam int UQ_W  = CD_W + 4;
   localparam int UQV_W = UQ_W - FRAC_BITS - 3;
   localparam int M1_W  = 2 * FRAC_W;
   localparam int M2_W  = FRAC_W + 1 + UQV_W;
   localparam int GF_W  = M2_W + 2;

   typedef struct packed {
      logic            kill;
      logic            den_zero;
      logic [CO_W-1:0] co;
   } dt_tag_type;

   typedef struct packed {
      logic                 kill;
      logic [FRAC_BITS-1:0] dt;
      logic [FRAC_W-1:0]    psi;
      logic [CO_W-1:0]      co;
      logic                 hc_sat;
   } hc_tag_type;

   typedef struct packed {
      logic zero;
      logic full;
   } beta_tag_type;

   logic                 rsp_valid_ff;
   logic [FRAC_W-1:0]    face_weight_ff;
   logic                 adv;

   // back moves unless a finished result waits
   assign adv = !rsp_valid_ff || !rsp_stall;
   assign pop = adv && !queue_status.empty;

   // normalized donor value and angle factor, divided side by side
   dt_tag_type           dt_tag_in, dt_tag_out;
   logic                 dt_valid, psi_valid;
   logic [FRAC_BITS-1:0] dt_quo, psi_quo;
   logic                 psi_ge_in, psi_ge_out;

   assign dt_tag_in = '{kill: head_item.kill, den_zero: head_item.den_zero, co: head_item.co};
   assign psi_ge_in = head_item.n2 >= head_item.d2;

   cfw_div_pipe #(
      .REM_W (FRAC_W),
      .STEPS (FRAC_BITS),
      .TAG_W ($bits(dt_tag_type))
   ) u_dt_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (!queue_status.empty),
      .in_rem    ({1'b0, head_item.num}),
      .in_den    (head_item.den),
      .in_tag    (dt_tag_in),
      .out_valid (dt_valid),
      .out_quo   (dt_quo),
      .out_tag   (dt_tag_out)
   );

   cfw_div_pipe #(
      .REM_W (PROD2_W),
      .STEPS (FRAC_BITS),
      .TAG_W (1)
   ) u_psi_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (!queue_status.empty),
      .in_rem    (psi_ge_in ? '0 : head_item.n2),
      .in_den    (head_item.d2),
      .in_tag    (psi_ge_in),
      .out_valid (psi_valid),
      .out_quo   (psi_quo),
      .out_tag   (psi_ge_out)
   );

   // hyper-c quotient
   logic [FRAC_BITS-1:0] dt_val;
   logic [FRAC_W-1:0]    psi_val;
   hc_tag_type           hc_tag_in, hc_tag_out;
   logic                 hc_valid;
   logic [FRAC_BITS-1:0] hc_quo;
   logic [FRAC_W-1:0]    hc_val;

   always_comb begin
      dt_val  = dt_tag_out.den_zero ? '0 : dt_quo;
      psi_val = psi_ge_out ? ONE_Q : {1'b0, psi_quo};
      hc_tag_in.kill   = dt_tag_out.kill;
      hc_tag_in.dt     = dt_val;
      hc_tag_in.psi    = psi_val;
      hc_tag_in.co     = dt_tag_out.co;
      hc_tag_in.hc_sat = (dt_tag_out.co == '0) || (CO_W'(dt_val) >= dt_tag_out.co);
   end

   cfw_div_pipe #(
      .REM_W (CO_W),
      .STEPS (FRAC_BITS),
      .TAG_W ($bits(hc_tag_type))
   ) u_hc_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (dt_valid && psi_valid),
      .in_rem    (hc_tag_in.hc_sat ? '0 : CO_W'(dt_val)),
      .in_den    (dt_tag_out.co),
      .in_tag    (hc_tag_in),
      .out_valid (hc_valid),
      .out_quo   (hc_quo),
      .out_tag   (hc_tag_out)
   );

   assign hc_val = hc_tag_out.hc_sat ? ONE_Q : {1'b0, hc_quo};

   // ultimate-quickest: courant times donor value
   logic                 u1_valid_ff, u1_kill_ff;
   logic [FRAC_BITS-1:0] u1_dt_ff;
   logic [FRAC_W-1:0]    u1_psi_ff, u1_hc_ff;
   logic [CO_W-1:0]      u1_co_ff;
   logic [CD_W-1:0]      u1_cd_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         u1_kill_ff <= hc_tag_out.kill;
         u1_dt_ff   <= hc_tag_out.dt;
         u1_psi_ff  <= hc_tag_out.psi;
         u1_hc_ff   <= hc_val;
         u1_co_ff   <= hc_tag_out.co;
         u1_cd_ff   <= hc_tag_out.co * hc_tag_out.dt;
      end
   end

   // ultimate-quickest: combine terms, floor divide by eight, cap by hyper-c
   logic [UQ_W-1:0]         pos_in, neg_in;
   logic signed [UQ_W-1:0]  diff_in;
   logic signed [UQ_W-1:0]  q_wide;
   logic signed [UQV_W-1:0] q_in, hc_s, uq_in;
   logic                    u2_valid_ff, u2_kill_ff;
   logic [FRAC_BITS-1:0]    u2_dt_ff;
   logic [FRAC_W-1:0]       u2_psi_ff, u2_hc_ff;
   logic signed [UQV_W-1:0] u2_uq_ff;

   always_comb begin
      pos_in  = (UQ_W'(u1_cd_ff) << 1) +
                ((UQ_W'(u1_dt_ff) * UQ_W'(6)) << FRAC_BITS) +
                (UQ_W'(3) << (2 * FRAC_BITS));
      neg_in  = (UQ_W'(u1_co_ff) * UQ_W'(3)) << FRAC_BITS;
      diff_in = $signed(pos_in - neg_in);
      q_wide  = diff_in >>> (FRAC_BITS + 3);
      q_in    = q_wide[UQV_W-1:0];
      hc_s    = $signed(UQV_W'(u1_hc_ff));
      uq_in   = (q_in < hc_s) ? q_in : hc_s;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         u2_kill_ff <= u1_kill_ff;
         u2_dt_ff   <= u1_dt_ff;
         u2_psi_ff  <= u1_psi_ff;
         u2_hc_ff   <= u1_hc_ff;
         u2_uq_ff   <= uq_in;
      end
   end

   // blend products
   logic                   g1_valid_ff, g1_kill_ff;
   logic [FRAC_BITS-1:0]   g1_dt_ff;
   logic [M1_W-1:0]        g1_m1_ff;
   logic signed [M2_W-1:0] g1_m2_ff;
   logic signed [M2_W-1:0] m2_in;

   assign m2_in = $signed({1'b0, ONE_Q - u2_psi_ff}) * u2_uq_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         g1_kill_ff <= u2_kill_ff;
         g1_dt_ff   <= u2_dt_ff;
         g1_m1_ff   <= u2_psi_ff * u2_hc_ff;
         g1_m2_ff   <= m2_in;
      end
   end

   // blended face value
   logic signed [GF_W-1:0] sum_in;
   logic                   g2_valid_ff, g2_kill_ff;
   logic [FRAC_BITS-1:0]   g2_dt_ff;
   logic signed [GF_W-1:0] g2_gf_ff;

   assign sum_in = $signed(GF_W'(g1_m1_ff)) + GF_W'(g1_m2_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         g2_kill_ff <= g1_kill_ff;
         g2_dt_ff   <= g1_dt_ff;
         g2_gf_ff   <= sum_in >>> FRAC_BITS;
      end
   end

   // weight quotient with saturation at both ends
   logic signed [GF_W-1:0] bnum;
   logic [FRAC_W-1:0]      bden;
   beta_tag_type           beta_tag_in, beta_tag_out;
   logic                   beta_valid;
   logic [FRAC_BITS-1:0]   beta_quo;

   always_comb begin
      bnum             = g2_gf_ff - $signed(GF_W'(g2_dt_ff));
      bden             = ONE_Q - FRAC_W'(g2_dt_ff);
      beta_tag_in.zero = g2_kill_ff || (bnum <= 0);
      beta_tag_in.full = bnum >= $signed(GF_W'(bden));
   end

   cfw_div_pipe #(
      .REM_W (FRAC_W),
      .STEPS (FRAC_BITS),
      .TAG_W ($bits(beta_tag_type))
   ) u_beta_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (g2_valid_ff),
      .in_rem    ((beta_tag_in.zero || beta_tag_in.full) ?
                  '0 : {1'b0, bnum[FRAC_BITS-1:0]}),
      .in_den    (bden),
      .in_tag    (beta_tag_in),
      .out_valid (beta_valid),
      .out_quo   (beta_quo),
      .out_tag   (beta_tag_out)
   );

   // valid bits of the blend stages and the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         u1_valid_ff  <= 1'b0;
         u2_valid_ff  <= 1'b0;
         g1_valid_ff  <= 1'b0;
         g2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         u1_valid_ff  <= hc_valid;
         u2_valid_ff  <= u1_valid_ff;
         g1_valid_ff  <= u2_valid_ff;
         g2_valid_ff  <= g1_valid_ff;
         rsp_valid_ff <= beta_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (beta_tag_out.zero) begin
            face_weight_ff <= '0;
         end else if (beta_tag_out.full) begin
            face_weight_ff <= ONE_Q;
         end else begin
            face_weight_ff <= {1'b0, beta_quo};
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_face_weight = face_weight_ff;

endmodule

`default_nettype wire

// ----- rtl/cicsam_face_weight_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake              payload
// req       in         req_valid / req_stall  gamma_donor, gamma_acceptor, dist_x/y,
//                                             grad_x/y, courant_donor
// rsp       out        rsp_valid / rsp_stall  face_weight
//
// One face per cycle enters while req_stall is low; each face passes the front stages,
// the queue, the three 16-step pipelined quotient units in series (dt, hyper-c,
// weight) and the blend multipliers.
// Reset clears all valid bits and the queue; no clearing pass.
// The front stalls only when its last stage cannot enter the queue; the back
// stalls as a whole while a result waits on rsp_stall.

module cicsam_face_weight_core #(
   parameter int FIFO_DEPTH = cfw_pkg::FIFO_DEPTH
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [cfw_pkg::FRAC_W-1:0]       req_gamma_donor,
   input  wire logic [cfw_pkg::FRAC_W-1:0]       req_gamma_acceptor,
   input  wire logic signed [cfw_pkg::VEC_W-1:0] req_dist_x,
   input  wire logic signed [cfw_pkg::VEC_W-1:0] req_dist_y,
   input  wire logic signed [cfw_pkg::VEC_W-1:0] req_grad_x,
   input  wire logic signed [cfw_pkg::VEC_W-1:0] req_grad_y,
   input  wire logic [cfw_pkg::CO_W-1:0]         req_courant_donor,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [cfw_pkg::FRAC_W-1:0]            rsp_face_weight
);

   import cfw_pkg::*;

   fifo_status_type queue_status;
   face_item_type   push_item, head_item;
   logic            push, pop;

   // classification front
   cfw_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_gamma_donor    (req_gamma_donor),
      .req_gamma_acceptor (req_gamma_acceptor),
      .req_dist_x         (req_dist_x),
      .req_dist_y         (req_dist_y),
      .req_grad_x         (req_grad_x),
      .req_grad_y         (req_grad_y),
      .req_courant_donor  (req_courant_donor),
      .queue_status       (queue_status),
      .push               (push),
      .push_item          (push_item)
   );

   // decoupling queue
   cfw_queue #(
      .DEPTH (FIFO_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .status    (queue_status)
   );

   // quotient and blend back
   cfw_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_item       (head_item),
      .queue_status    (queue_status),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_face_weight (rsp_face_weight)
   );

`ifndef ASSERT_OFF
   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_face_weight <= ONE_Q)
      else $error("face weight above one");

   a_no_pop_on_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !pop)
      else $error("queue popped while result held");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> queue_status.full)
      else $error("input stalled with room in queue");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !queue_status.full)
      else $error("queue overflow");
`endif

endmodule

`default_nettype wire
